>>> rtl/core/lpc_pkg.sv
// Shared constants, codes and types of the pair lookup LRU cache.
package lpc_pkg;

    // Entry count of the cache and derived widths
    localparam int CAPACITY  = 16;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W     = $clog2(CAPACITY + 1);

    // Field widths
    localparam int KIND_W    = 2;
    localparam int NODE_W    = 24;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 5;
    localparam int OCC_OUT_W = 5;
    localparam int CMP_W     = OCC_W + CFG_W;

    // Register port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic [CFG_W-1:0] CAP_RESET    = 5'd16;
    localparam logic             REG_CAPACITY = 1'b0;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ZERO   = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic              found;
        logic [NODE_W-1:0] rec;
    } t_item;

    // Request to the entry store: one item per cycle when go is set
    typedef struct packed {
        logic             go;
        t_item            item;
        logic [OCC_W-1:0] cap;
    } t_req;

    // Lookup answer for the item at the input of the store
    typedef struct packed {
        logic             hit;
        logic [NODE_W-1:0] row;
        logic [OCC_W-1:0] occ;
    } t_rsp;

endpackage

>>> rtl/core/lpc_lru_core.sv
// Entry store of the cache: parallel pair match, recency ranks and LRU replacement.
module lpc_lru_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lpc_pkg::t_req i_req,
    output lpc_pkg::t_rsp o_rsp
);

    localparam int N = lpc_pkg::CAPACITY;

    logic [N-1:0]                    r_valid, n_valid;
    logic [lpc_pkg::IDX_W-1:0]       r_age [N];
    logic [lpc_pkg::IDX_W-1:0]       n_age [N];
    logic [lpc_pkg::NODE_W-1:0]      r_src [N];
    logic [lpc_pkg::NODE_W-1:0]      r_dst [N];
    logic [lpc_pkg::NODE_W-1:0]      r_row [N];
    logic [lpc_pkg::OCC_W-1:0]       r_occ, n_occ;

    logic [N-1:0]                    match;
    logic                            hit_any;
    logic [lpc_pkg::IDX_W-1:0]       hit_age;
    logic [lpc_pkg::NODE_W-1:0]      hit_row;
    logic                            is_fill;
    logic                            do_clear;
    logic                            do_touch;
    logic                            do_insert;
    logic                            evict;
    logic [lpc_pkg::OCC_W-1:0]       occ_m1;
    logic [N-1:0]                    vic_raw, vic_oh;
    logic [N-1:0]                    kept;
    logic [N-1:0]                    free_raw, free_oh;
    logic [N-1:0]                    ins_oh;
    logic [N-1:0]                    row_we;

    // Compare every entry against the pair; at most one can match
    always_comb begin
        hit_age = '0;
        hit_row = '0;
        for (int i = 0; i < N; i++) begin
            match[i] = r_valid[i] && (r_src[i] == i_req.item.src)
                                  && (r_dst[i] == i_req.item.dst);
            if (match[i]) begin
                hit_age = hit_age | r_age[i];
                hit_row = hit_row | r_row[i];
            end
        end
        hit_any = |match;
    end

    // Decode what this item does to the store
    assign is_fill   = (i_req.item.kind == lpc_pkg::KIND_FILL) && i_req.item.found;
    assign do_clear  = i_req.go && (i_req.item.kind == lpc_pkg::KIND_CLEAR);
    assign do_touch  = i_req.go && hit_any &&
                       ((i_req.item.kind == lpc_pkg::KIND_LOOKUP) || is_fill);
    assign do_insert = i_req.go && is_fill && !hit_any;
    assign evict     = do_insert && (r_occ >= i_req.cap);

    // Victim is the valid entry with the oldest rank (occupancy - 1)
    assign occ_m1 = r_occ - lpc_pkg::OCC_W'(1);
    always_comb begin
        for (int i = 0; i < N; i++) begin
            vic_raw[i] = r_valid[i] && (lpc_pkg::OCC_W'(r_age[i]) == occ_m1);
        end
    end
    assign vic_oh   = vic_raw & (~vic_raw + N'(1));
    assign kept     = r_valid & ~(evict ? vic_oh : '0);
    // Lowest free slot after the eviction
    assign free_raw = ~kept;
    assign free_oh  = free_raw & (~free_raw + N'(1));
    assign ins_oh   = do_insert ? free_oh : '0;
    assign row_we   = ins_oh | ((do_touch && is_fill) ? match : '0);

    // Next valid bits, ranks and occupancy
    always_comb begin
        n_valid = r_valid;
        n_age   = r_age;
        n_occ   = r_occ;
        if (do_clear) begin
            n_valid = '0;
            n_occ   = '0;
            for (int i = 0; i < N; i++) begin
                n_age[i] = '0;
            end
        end else if (do_touch) begin
            for (int i = 0; i < N; i++) begin
                if (match[i]) begin
                    n_age[i] = '0;
                end else if (r_valid[i] && (r_age[i] < hit_age)) begin
                    n_age[i] = r_age[i] + lpc_pkg::IDX_W'(1);
                end
            end
        end else if (do_insert) begin
            n_valid = kept | free_oh;
            n_occ   = evict ? r_occ : r_occ + lpc_pkg::OCC_W'(1);
            for (int i = 0; i < N; i++) begin
                if (free_oh[i]) begin
                    n_age[i] = '0;
                end else if (kept[i]) begin
                    n_age[i] = r_age[i] + lpc_pkg::IDX_W'(1);
                end else if (r_valid[i]) begin
                    n_age[i] = '0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < N; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            r_age   <= n_age;
        end
    end

    // Entry payload, written on insert or refill
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (ins_oh[i]) begin
                r_src[i] <= i_req.item.src;
                r_dst[i] <= i_req.item.dst;
            end
            if (row_we[i]) begin
                r_row[i] <= i_req.item.rec;
            end
        end
    end

    assign o_rsp.hit = hit_any;
    assign o_rsp.row = hit_row;
    assign o_rsp.occ = r_occ;

endmodule

>>> rtl/core/lru_pair_lookup_cache.sv
// Each item passes the input register, then the result register; i_out_stall holds the result.
// Throughput: one item per cycle while the result channel is not stalled; all 16 entries
// are matched and updated in one pass between the input register and the result register.
// Reset: synchronous, active low; clears all entries, ranks, both counters and the
// pipeline valids, and sets capacity_in_use to 16.
// Top level of the pair lookup LRU cache.
module lru_pair_lookup_cache (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lpc_pkg::KIND_W-1:0]   i_kind,
    input  logic [lpc_pkg::NODE_W-1:0]   i_source_node,
    input  logic [lpc_pkg::NODE_W-1:0]   i_target_node,
    input  logic                         i_fill_found,
    input  logic [lpc_pkg::NODE_W-1:0]   i_fill_record,
    // Result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic                         o_need_fill,
    output logic                         o_record_valid,
    output logic [lpc_pkg::NODE_W-1:0]   o_record_row,
    output logic [lpc_pkg::CNT_W-1:0]    o_hit_total,
    output logic [lpc_pkg::CNT_W-1:0]    o_miss_total,
    output logic [lpc_pkg::OCC_OUT_W-1:0] o_occupancy,
    // Register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [lpc_pkg::DATA_W-1:0]   pwdata,
    output logic [lpc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    logic                          r_s1_valid;
    lpc_pkg::t_item                r_s1;
    logic                          r_out_valid;
    logic                          r_hit, n_hit;
    logic                          r_need, n_need;
    logic                          r_rvalid, n_rvalid;
    logic [lpc_pkg::NODE_W-1:0]    r_row, n_row;
    logic [lpc_pkg::CNT_W-1:0]     r_hit_cnt, n_hit_cnt;
    logic [lpc_pkg::CNT_W-1:0]     r_miss_cnt, n_miss_cnt;
    logic [lpc_pkg::CFG_W-1:0]     r_cap;

    logic                          accept;
    logic                          advance;
    logic                          cfg_wr;
    logic                          is_lookup;
    logic [lpc_pkg::CMP_W-1:0]     cap_ext;
    logic [lpc_pkg::CMP_W-1:0]     cap_eff;
    logic [lpc_pkg::CMP_W-1:0]     occ_ext;
    lpc_pkg::t_req                 req;
    lpc_pkg::t_rsp                 rsp;

    // Handshake: stage 1 moves on when the result register is free or being drained
    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == lpc_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == lpc_pkg::REG_CAPACITY) ?
                    lpc_pkg::DATA_W'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lpc_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[lpc_pkg::CFG_W-1:0];
        end
    end

    // Effective capacity: zero acts as one, large values clip to the entry count
    always_comb begin
        cap_ext = lpc_pkg::CMP_W'(r_cap);
        cap_eff = cap_ext;
        if (cap_ext == '0) begin
            cap_eff = lpc_pkg::CMP_W'(1);
        end else if (cap_ext > lpc_pkg::CMP_W'(lpc_pkg::CAPACITY)) begin
            cap_eff = lpc_pkg::CMP_W'(lpc_pkg::CAPACITY);
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.kind  <= i_kind;
            r_s1.src   <= i_source_node;
            r_s1.dst   <= i_target_node;
            r_s1.found <= i_fill_found;
            r_s1.rec   <= i_fill_record;
        end
    end

    // Entry store
    assign req.go   = advance;
    assign req.item = r_s1;
    assign req.cap  = cap_eff[lpc_pkg::OCC_W-1:0];

    lpc_lru_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Result fields and counters for the item in stage 1
    assign is_lookup = (r_s1.kind == lpc_pkg::KIND_LOOKUP);
    always_comb begin
        n_hit      = is_lookup && rsp.hit;
        n_need     = is_lookup && !rsp.hit;
        n_rvalid   = 1'b0;
        n_row      = '0;
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        case (r_s1.kind)
            lpc_pkg::KIND_LOOKUP: begin
                if (rsp.hit) begin
                    n_rvalid = 1'b1;
                    n_row    = rsp.row;
                    if (r_hit_cnt != '1) begin
                        n_hit_cnt = r_hit_cnt + lpc_pkg::CNT_W'(1);
                    end
                end else if (r_miss_cnt != '1) begin
                    n_miss_cnt = r_miss_cnt + lpc_pkg::CNT_W'(1);
                end
            end
            lpc_pkg::KIND_FILL: begin
                if (r_s1.found) begin
                    n_rvalid = 1'b1;
                    n_row    = r_s1.rec;
                end
            end
            lpc_pkg::KIND_ZERO: begin
                n_hit_cnt  = '0;
                n_miss_cnt = '0;
            end
            default: begin
            end
        endcase
    end

    // Result register; counters only move with a transfer into it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
        end else begin
            r_out_valid <= advance || (r_out_valid && i_out_stall);
            if (advance) begin
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_hit    <= n_hit;
            r_need   <= n_need;
            r_rvalid <= n_rvalid;
            r_row    <= n_row;
        end
    end

    assign occ_ext        = lpc_pkg::CMP_W'(rsp.occ);
    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_need_fill    = r_need;
    assign o_record_valid = r_rvalid;
    assign o_record_row   = r_row;
    assign o_hit_total    = r_hit_cnt;
    assign o_miss_total   = r_miss_cnt;
    assign o_occupancy    = occ_ext[lpc_pkg::OCC_OUT_W-1:0];

    // Checks
    a_hit_xor_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_need))
        else $error("hit and need_fill both set");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_ext <= lpc_pkg::CMP_W'(lpc_pkg::CAPACITY))
        else $error("occupancy above entry count");

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_hit_cnt) && $stable(r_miss_cnt)))
        else $error("counter moved without a transfer");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item lost from input register");

endmodule
